@@ sv/spq_pkg.sv @@
// Shared types, constants and helper functions of the strict-priority packet queue.
`default_nettype none

package spq_pkg;

    // Queue geometry.
    localparam int FIFO_DEPTH  = 64;
    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int PTR_W       = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH   = NUM_CLASSES * FIFO_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Field widths.
    localparam int TYPE_W  = 4;
    localparam int SIZE_W  = 14;
    localparam int TAG_W   = 16;
    localparam int STAT_W  = 3;
    localparam int SERV_W  = 3;
    localparam int WAIT_W  = 40;
    localparam int TOTAL_W = 40;
    localparam int PPB_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Byte counts held in a class and all classes above it.
    localparam int SUFFIX_W = $clog2(MEM_DEPTH * ((2 ** SIZE_W) - 1) + 1);
    localparam int PROD_W   = SUFFIX_W + PPB_W;
    localparam int WIDE_W   = (PROD_W > WAIT_W) ? PROD_W : WAIT_W;
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // Serving indication when no class is selected.
    localparam logic [SERV_W-1:0] IDLE_CLASS = SERV_W'(NUM_CLASSES);

    // Opcodes.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SENT     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // Packet type code boundaries.
    localparam logic [TYPE_W-1:0] TYPE_LAST_CTRL = 4'd6;
    localparam logic [TYPE_W-1:0] TYPE_NDP       = 4'd7;
    localparam logic [TYPE_W-1:0] TYPE_LAST_BULK = 4'd10;

    // Fixed class assignments.
    localparam logic [CLS_W-1:0] CLS_CTRL    = 2'd3;
    localparam logic [CLS_W-1:0] CLS_NDP_HDR = 2'd3;
    localparam logic [CLS_W-1:0] CLS_NDP_RTX = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NDP_NEW = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BULK    = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_RETX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_NEW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PS_PER_BYTE = 2'd3;

    // Configuration reset values.
    localparam logic [CLS_W-1:0] RST_LONG_HEADER = 2'd3;
    localparam logic [CLS_W-1:0] RST_LONG_RETX   = 2'd2;
    localparam logic [CLS_W-1:0] RST_LONG_NEW    = 2'd1;
    localparam logic [PPB_W-1:0] RST_PS_PER_BYTE = 16'd80;

    // One stored descriptor.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // One input beat.
    typedef struct packed {
        logic              opcode;
        logic [TYPE_W-1:0] type_code;
        logic              header_only;
        logic              long_flow;
        logic              retransmitted;
        logic [SIZE_W-1:0] pkt_size;
        logic [TAG_W-1:0]  pkt_tag;
    } item_t;

    // Long-flow class settings used by the classifier.
    typedef struct packed {
        logic [CLS_W-1:0] long_header_class;
        logic [CLS_W-1:0] long_retx_class;
        logic [CLS_W-1:0] long_new_class;
    } class_cfg_t;

    // Classifier verdict.
    typedef struct packed {
        logic             known;
        logic [CLS_W-1:0] cls;
    } cls_res_t;

    // Result held between the state-update stage and the output stage.
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [CLS_W-1:0]    chosen_class;
        logic [SUFFIX_W-1:0] ahead;
        logic [TAG_W-1:0]    sent_tag;
        logic [SIZE_W-1:0]   sent_size;
        logic [SERV_W-1:0]   serving_class;
        logic [TOTAL_W-1:0]  bytes_sent_total;
    } mid_item_t;

    // Advance a ring pointer by one place.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end
        else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Flat descriptor memory address of one slot of one class.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] c,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(c) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

`default_nettype wire

@@ sv/strict_priority_packet_queue.sv @@
// Top level of the four-class strict-priority packet descriptor queue.
// Accepts one beat per clock while in_stall is low and returns one result beat for
// each. The first register stage applies the beat to the class rings, byte sums and
// descriptor memory; the second turns the queued byte count into a wait estimate
// through one multiplier. The head descriptor of each class sits in a register, so
// back-to-back services read it without waiting on the memory port; the memory
// supplies the next head in the cycle after each pop.
// The descriptor memory needs no clearing after reset. Configuration may be written
// only while no beat is in flight.
`default_nettype none

module strict_priority_packet_queue (
    input  wire                              clk,
    input  wire                              rst_n,
    // Configuration write port.
    input  wire                              cfg_wr_en,
    input  wire [spq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [spq_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input channel.
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              opcode,
    input  wire [spq_pkg::TYPE_W-1:0]        type_code,
    input  wire                              header_only,
    input  wire                              long_flow,
    input  wire                              retransmitted,
    input  wire [spq_pkg::SIZE_W-1:0]        pkt_size,
    input  wire [spq_pkg::TAG_W-1:0]         pkt_tag,
    // Output channel.
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [spq_pkg::STAT_W-1:0]       status,
    output logic [spq_pkg::CLS_W-1:0]        chosen_class,
    output logic [spq_pkg::WAIT_W-1:0]       wait_ps,
    output logic [spq_pkg::TAG_W-1:0]        sent_tag,
    output logic [spq_pkg::SIZE_W-1:0]       sent_size,
    output logic [spq_pkg::SERV_W-1:0]       serving_class,
    output logic [spq_pkg::TOTAL_W-1:0]      bytes_sent_total
);

    spq_pkg::class_cfg_t         class_cfg_reg;
    logic [spq_pkg::PPB_W-1:0]   ps_per_byte_reg;

    spq_pkg::item_t              item;
    spq_pkg::cls_res_t           cls_res;
    logic                        item_accept;
    logic                        mid_advance;
    logic                        out_advance;
    logic                        mid_valid;
    spq_pkg::mid_item_t          mid_item;

    logic [spq_pkg::PROD_W-1:0]  wait_prod;
    logic [spq_pkg::WIDE_W-1:0]  wait_wide;
    logic [spq_pkg::WAIT_W-1:0]  wait_sat;

    logic                        out_valid_reg;
    logic [spq_pkg::STAT_W-1:0]  status_reg;
    logic [spq_pkg::CLS_W-1:0]   chosen_class_reg;
    logic [spq_pkg::WAIT_W-1:0]  wait_ps_reg;
    logic [spq_pkg::TAG_W-1:0]   sent_tag_reg;
    logic [spq_pkg::SIZE_W-1:0]  sent_size_reg;
    logic [spq_pkg::SERV_W-1:0]  serving_class_reg;
    logic [spq_pkg::TOTAL_W-1:0] bytes_sent_total_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            class_cfg_reg.long_header_class <= spq_pkg::RST_LONG_HEADER;
            class_cfg_reg.long_retx_class   <= spq_pkg::RST_LONG_RETX;
            class_cfg_reg.long_new_class    <= spq_pkg::RST_LONG_NEW;
            ps_per_byte_reg                 <= spq_pkg::RST_PS_PER_BYTE;
        end
        else if (cfg_wr_en) begin
            case (cfg_index)
                spq_pkg::CFG_LONG_HEADER:
                    class_cfg_reg.long_header_class <= cfg_data[spq_pkg::CLS_W-1:0];
                spq_pkg::CFG_LONG_RETX:
                    class_cfg_reg.long_retx_class <= cfg_data[spq_pkg::CLS_W-1:0];
                spq_pkg::CFG_LONG_NEW:
                    class_cfg_reg.long_new_class <= cfg_data[spq_pkg::CLS_W-1:0];
                spq_pkg::CFG_PS_PER_BYTE:
                    ps_per_byte_reg <= cfg_data[spq_pkg::PPB_W-1:0];
                default:
                    ps_per_byte_reg <= ps_per_byte_reg;
            endcase
        end
    end

    // Pipeline flow: each stage moves when the one after it has room.
    always_comb
    begin
        out_advance = !out_valid_reg || !out_stall;
        mid_advance = !mid_valid || out_advance;
        in_stall    = !mid_advance;
        item_accept = in_valid && mid_advance;
    end

    assign item = '{opcode: opcode, type_code: type_code, header_only: header_only,
                    long_flow: long_flow, retransmitted: retransmitted,
                    pkt_size: pkt_size, pkt_tag: pkt_tag};

    spq_classify u_classify (
        .item (item),
        .cfg  (class_cfg_reg),
        .res  (cls_res)
    );

    spq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .mid_advance (mid_advance),
        .item        (item),
        .cls_in      (cls_res),
        .mid_valid   (mid_valid),
        .mid_item    (mid_item)
    );

    // Wait estimate: queued bytes ahead times the per-byte time, saturated.
    always_comb
    begin
        wait_prod = spq_pkg::PROD_W'(mid_item.ahead) * spq_pkg::PROD_W'(ps_per_byte_reg);
        wait_wide = spq_pkg::WIDE_W'(wait_prod);
        if (wait_wide > spq_pkg::WIDE_W'(spq_pkg::WAIT_MAX)) begin
            wait_sat = spq_pkg::WAIT_MAX;
        end
        else begin
            wait_sat = wait_wide[spq_pkg::WAIT_W-1:0];
        end
    end

    // Output stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance) begin
            out_valid_reg <= mid_valid;
        end
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (out_advance && mid_valid) begin
            status_reg           <= mid_item.status;
            chosen_class_reg     <= mid_item.chosen_class;
            wait_ps_reg          <= wait_sat;
            sent_tag_reg         <= mid_item.sent_tag;
            sent_size_reg        <= mid_item.sent_size;
            serving_class_reg    <= mid_item.serving_class;
            bytes_sent_total_reg <= mid_item.bytes_sent_total;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign chosen_class     = chosen_class_reg;
    assign wait_ps          = wait_ps_reg;
    assign sent_tag         = sent_tag_reg;
    assign sent_size        = sent_size_reg;
    assign serving_class    = serving_class_reg;
    assign bytes_sent_total = bytes_sent_total_reg;

endmodule

`default_nettype wire

@@ sv/spq_classify.sv @@
// Packet classifier: maps type code and flags to a traffic class.
`default_nettype none

module spq_classify (
    input  wire spq_pkg::item_t      item,
    input  wire spq_pkg::class_cfg_t cfg,
    output spq_pkg::cls_res_t        res
);

    // Control traffic goes top, NDP data by its flags, other known types to bulk.
    always_comb
    begin
        res.known = 1'b1;
        res.cls   = spq_pkg::CLS_BULK;
        if (item.type_code <= spq_pkg::TYPE_LAST_CTRL) begin
            res.cls = spq_pkg::CLS_CTRL;
        end
        else if (item.type_code == spq_pkg::TYPE_NDP) begin
            if (item.header_only) begin
                res.cls = item.long_flow ? cfg.long_header_class : spq_pkg::CLS_NDP_HDR;
            end
            else if (item.retransmitted) begin
                res.cls = item.long_flow ? cfg.long_retx_class : spq_pkg::CLS_NDP_RTX;
            end
            else begin
                res.cls = item.long_flow ? cfg.long_new_class : spq_pkg::CLS_NDP_NEW;
            end
        end
        else if (item.type_code <= spq_pkg::TYPE_LAST_BULK) begin
            res.cls = spq_pkg::CLS_BULK;
        end
        else begin
            res.known = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ sv/spq_core.sv @@
// Queue state, descriptor memory and the first pipeline register.
`default_nettype none

module spq_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     item_accept,
    input  wire                     mid_advance,
    input  wire spq_pkg::item_t     item,
    input  wire spq_pkg::cls_res_t  cls_in,
    output logic                    mid_valid,
    output spq_pkg::mid_item_t      mid_item
);

    localparam int NC = spq_pkg::NUM_CLASSES;

    // Per-class ring state.
    logic [spq_pkg::PTR_W-1:0]    head_ptr_reg  [NC];
    logic [spq_pkg::PTR_W-1:0]    head_ptr_next [NC];
    logic [spq_pkg::PTR_W-1:0]    tail_ptr_reg  [NC];
    logic [spq_pkg::PTR_W-1:0]    tail_ptr_next [NC];
    logic [spq_pkg::CNT_W-1:0]    count_reg     [NC];
    logic [spq_pkg::CNT_W-1:0]    count_next    [NC];
    logic [spq_pkg::SUFFIX_W-1:0] suffix_reg    [NC];
    logic [spq_pkg::SUFFIX_W-1:0] suffix_next   [NC];

    // Head descriptor of each class, kept out of the memory.
    spq_pkg::entry_t head_data_reg [NC];

    logic [spq_pkg::SERV_W-1:0]  serving_reg;
    logic [spq_pkg::SERV_W-1:0]  serving_next;
    logic [spq_pkg::TOTAL_W-1:0] sent_total_reg;
    logic [spq_pkg::TOTAL_W-1:0] sent_total_next;

    // Head refill read in flight.
    logic                      refill_pend_reg;
    logic                      refill_next;
    logic [spq_pkg::CLS_W-1:0] refill_cls_reg;
    spq_pkg::entry_t           rd_data_reg;

    spq_pkg::entry_t mem_reg [spq_pkg::MEM_DEPTH];

    logic                  mid_valid_reg;
    spq_pkg::mid_item_t    mid_reg;
    spq_pkg::mid_item_t    mid_next;

    logic [NC-1:0]                nonempty_vec;
    logic [NC-1:0]                nonempty_next;
    logic [NC-1:0]                full_vec;
    logic                         enq_sel;
    logic                         enq_ok;
    logic                         pop_ok;
    logic [spq_pkg::CLS_W-1:0]    cls;
    logic [spq_pkg::CLS_W-1:0]    srv_idx;
    logic                         srv_busy;
    spq_pkg::entry_t              head_val;
    spq_pkg::entry_t              new_entry;
    logic [spq_pkg::PTR_W-1:0]    pop_ptr;
    logic [spq_pkg::SUFFIX_W-1:0] ahead;
    logic [spq_pkg::SERV_W-1:0]   select_class;

    // Occupancy flags, one per class.
    always_comb
    begin
        for (int k = 0; k < NC; k++) begin
            nonempty_vec[k] = count_reg[k] != '0;
            full_vec[k]     = count_reg[k] == spq_pkg::CNT_W'(spq_pkg::FIFO_DEPTH);
        end
    end

    // Decode the beat against the current state.
    always_comb
    begin
        enq_sel   = item.opcode == spq_pkg::OP_ENQUEUE;
        cls       = cls_in.cls;
        srv_idx   = serving_reg[spq_pkg::CLS_W-1:0];
        srv_busy  = (serving_reg != spq_pkg::IDLE_CLASS) && nonempty_vec[srv_idx];
        enq_ok    = item_accept && enq_sel && cls_in.known && !full_vec[cls];
        pop_ok    = item_accept && !enq_sel && srv_busy;
        head_val  = (refill_pend_reg && (refill_cls_reg == srv_idx)) ? rd_data_reg
                                                                     : head_data_reg[srv_idx];
        new_entry = '{tag: item.pkt_tag, size: item.pkt_size};
        pop_ptr   = spq_pkg::ptr_inc(head_ptr_reg[srv_idx]);
        ahead     = suffix_reg[cls] + spq_pkg::SUFFIX_W'(item.pkt_size);
        refill_next = pop_ok && (count_reg[srv_idx] > spq_pkg::CNT_W'(1));
    end

    // Next pointers, counts and byte sums.
    always_comb
    begin
        for (int k = 0; k < NC; k++) begin
            head_ptr_next[k] = head_ptr_reg[k];
            tail_ptr_next[k] = tail_ptr_reg[k];
            count_next[k]    = count_reg[k];
            suffix_next[k]   = suffix_reg[k];
            if (enq_ok && (spq_pkg::CLS_W'(k) == cls)) begin
                tail_ptr_next[k] = spq_pkg::ptr_inc(tail_ptr_reg[k]);
                count_next[k]    = count_reg[k] + spq_pkg::CNT_W'(1);
            end
            if (pop_ok && (spq_pkg::CLS_W'(k) == srv_idx)) begin
                head_ptr_next[k] = pop_ptr;
                count_next[k]    = count_reg[k] - spq_pkg::CNT_W'(1);
            end
            if (enq_ok && (spq_pkg::CLS_W'(k) <= cls)) begin
                suffix_next[k] = suffix_reg[k] + spq_pkg::SUFFIX_W'(item.pkt_size);
            end
            else if (pop_ok && (spq_pkg::CLS_W'(k) <= srv_idx)) begin
                suffix_next[k] = suffix_reg[k] - spq_pkg::SUFFIX_W'(head_val.size);
            end
            nonempty_next[k] = count_next[k] != '0;
        end
    end

    // Highest non-empty class after this beat, or idle.
    always_comb
    begin
        select_class = spq_pkg::IDLE_CLASS;
        for (int k = 0; k < NC; k++) begin
            if (nonempty_next[k]) begin
                select_class = spq_pkg::SERV_W'(k);
            end
        end
    end

    // Serving selection, sent total and the result of the beat.
    always_comb
    begin
        serving_next    = serving_reg;
        sent_total_next = sent_total_reg;
        mid_next        = '0;
        if (enq_sel) begin
            if (!cls_in.known) begin
                mid_next.status = spq_pkg::ST_UNKNOWN;
            end
            else if (full_vec[cls]) begin
                mid_next.status       = spq_pkg::ST_FULL;
                mid_next.chosen_class = cls;
            end
            else begin
                mid_next.status       = spq_pkg::ST_ENQUEUED;
                mid_next.chosen_class = cls;
                mid_next.ahead        = ahead;
                if (serving_reg == spq_pkg::IDLE_CLASS) begin
                    serving_next = select_class;
                end
            end
        end
        else begin
            if (srv_busy) begin
                mid_next.status       = spq_pkg::ST_SENT;
                mid_next.chosen_class = srv_idx;
                mid_next.sent_tag     = head_val.tag;
                mid_next.sent_size    = head_val.size;
                sent_total_next = sent_total_reg + spq_pkg::TOTAL_W'(head_val.size);
            end
            else begin
                mid_next.status = spq_pkg::ST_NOTHING;
            end
            serving_next = select_class;
        end
        mid_next.serving_class    = serving_next;
        mid_next.bytes_sent_total = sent_total_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < NC; k++) begin
                head_ptr_reg[k] <= '0;
                tail_ptr_reg[k] <= '0;
                count_reg[k]    <= '0;
                suffix_reg[k]   <= '0;
            end
            serving_reg     <= spq_pkg::IDLE_CLASS;
            sent_total_reg  <= '0;
            refill_pend_reg <= 1'b0;
            refill_cls_reg  <= '0;
            mid_valid_reg   <= 1'b0;
        end
        else begin
            if (item_accept) begin
                for (int k = 0; k < NC; k++) begin
                    head_ptr_reg[k] <= head_ptr_next[k];
                    tail_ptr_reg[k] <= tail_ptr_next[k];
                    count_reg[k]    <= count_next[k];
                    suffix_reg[k]   <= suffix_next[k];
                end
                serving_reg    <= serving_next;
                sent_total_reg <= sent_total_next;
            end
            refill_pend_reg <= refill_next;
            if (refill_next) begin
                refill_cls_reg <= srv_idx;
            end
            if (mid_advance) begin
                mid_valid_reg <= item_accept;
            end
        end
    end

    // Head descriptors: a refill is read into rd_data_reg and then lands here; a beat
    // into an empty class becomes the head at once.
    always_ff @(posedge clk)
    begin
        if (refill_pend_reg) begin
            head_data_reg[refill_cls_reg] <= rd_data_reg;
        end
        if (enq_ok && !nonempty_vec[cls]) begin
            head_data_reg[cls] <= new_entry;
        end
        if (item_accept) begin
            mid_reg <= mid_next;
        end
    end

    // Descriptor memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (enq_ok) begin
            mem_reg[spq_pkg::mem_addr(cls, tail_ptr_reg[cls])] <= new_entry;
        end
        if (refill_next) begin
            rd_data_reg <= mem_reg[spq_pkg::mem_addr(srv_idx, pop_ptr)];
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_item  = mid_reg;

    // A selected class always holds at least one descriptor.
    a_serving_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (serving_reg != spq_pkg::IDLE_CLASS) |-> nonempty_vec[srv_idx])
        else $error("serving class is empty");

    // Idle means every class is empty.
    a_idle_all_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (serving_reg == spq_pkg::IDLE_CLASS) |-> (nonempty_vec == '0))
        else $error("idle while a class holds descriptors");

    // A head refill only targets a class that still has a head.
    a_refill_target: assert property (@(posedge clk) disable iff (!rst_n)
        refill_pend_reg |-> nonempty_vec[refill_cls_reg])
        else $error("head refill into an empty class");

    // Byte sums over higher classes never exceed those over lower ones.
    a_suffix_order: assert property (@(posedge clk) disable iff (!rst_n)
        (suffix_reg[1] <= suffix_reg[0]) && (suffix_reg[2] <= suffix_reg[1])
        && (suffix_reg[3] <= suffix_reg[2]))
        else $error("class byte sums out of order");

endmodule

`default_nettype wire
